### rtl/imu_idf_pkg.sv
`timescale 1ns / 1ps

package imu_idf_pkg;

    localparam int NUM_CH       = 6;
    localparam int RING_ENTRIES = 8;
    localparam int SLOT_W       = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;

    localparam int SAMPLE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int FILL_W   = 8;
    localparam int WEIGHT_W = 15;
    localparam int PERIOD_W = 16;
    localparam int DECIM_W  = 8;

    // Stream layouts.
    localparam int IN_TDATA_W  = 144;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
    localparam logic [DECIM_W-1:0]  DECIM_RESET  = 8'd5;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 15'd10000;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] t_chan_vec;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_ring_ctrl;

    typedef struct packed {
        logic               popped;
        logic [STAMP_W-1:0] stamp;
        logic [FILL_W-1:0]  fill;
    } t_ring_status;

endpackage

### rtl/imu_idf_lane.sv
`timescale 1ns / 1ps

module imu_idf_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_update,
    input  logic [imu_idf_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [imu_idf_pkg::WEIGHT_W-1:0]    i_weight,
    output logic [imu_idf_pkg::SAMPLE_W-1:0]    o_next
);

    localparam logic signed [33:0] ROUND_HALF = 34'sd16384;
    localparam logic signed [33:0] SAT_HI     = 34'sh0_3FFF_FFFF;
    localparam logic signed [33:0] SAT_LO     = -34'sh0_4000_0000;

    logic [imu_idf_pkg::SAMPLE_W-1:0] r_filt;
    logic signed [16:0] diff;
    logic signed [32:0] prod;
    logic signed [33:0] acc;
    logic signed [33:0] sat;
    logic [imu_idf_pkg::SAMPLE_W-1:0] n_filt;

    // old*w + new*(32768-w) is rewritten as new*32768 + (old-new)*w,
    // which needs one multiplier per lane.
    always_comb begin
        diff = $signed({r_filt[15], r_filt}) - $signed({i_sample[15], i_sample});
        prod = diff * $signed({1'b0, i_weight});
        acc  = ROUND_HALF + $signed({{3{i_sample[15]}}, i_sample, 15'b0})
             + $signed({prod[32], prod});
        if (acc > SAT_HI) begin
            sat = SAT_HI;
        end else if (acc < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = acc;
        end
        // The clipped value fits in 31 bits, so bits 30..15 are the floor shift.
        n_filt = i_update ? sat[30:15] : r_filt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else begin
            r_filt <= n_filt;
        end
    end

    assign o_next = n_filt;

endmodule

### rtl/imu_idf_ring.sv
`timescale 1ns / 1ps

module imu_idf_ring (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  imu_idf_pkg::t_ring_ctrl             i_ctrl,
    input  logic [imu_idf_pkg::STAMP_W-1:0]     i_stamp,
    input  imu_idf_pkg::t_chan_vec              i_chan,
    output imu_idf_pkg::t_ring_status           o_status,
    output imu_idf_pkg::t_chan_vec              o_chan
);

    localparam int N  = imu_idf_pkg::RING_ENTRIES;
    localparam int SW = imu_idf_pkg::SLOT_W;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        if (s == SW'(N - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_diff(input logic [SW-1:0] w,
                                                input logic [SW-1:0] r);
        if (w >= r) begin
            return w - r;
        end
        return SW'(N - int'(r) + int'(w));
    endfunction

    logic [SW-1:0] r_wr_slot;
    logic [SW-1:0] r_rd_slot;
    logic [SW-1:0] n_wr_slot;
    logic [SW-1:0] n_rd_slot;
    logic [SW-1:0] wr_next;
    logic [SW-1:0] rd_next;
    logic [SW-1:0] head_slot;
    logic [SW-1:0] waiting;
    logic          do_push;
    logic          do_pop;

    logic [imu_idf_pkg::STAMP_W-1:0] r_stamps [N];
    imu_idf_pkg::t_chan_vec          r_chans  [N];
    logic [imu_idf_pkg::STAMP_W-1:0] r_head_stamp;
    imu_idf_pkg::t_chan_vec          r_head_chan;

    always_comb begin
        wr_next   = slot_inc(r_wr_slot);
        rd_next   = slot_inc(r_rd_slot);
        waiting   = slot_diff(r_wr_slot, r_rd_slot);
        do_push   = i_ctrl.push && (waiting < SW'(N - 1));
        do_pop    = i_ctrl.pop && (waiting != '0);
        n_wr_slot = do_push ? wr_next : r_wr_slot;
        if (i_ctrl.flush) begin
            n_rd_slot = r_wr_slot;
        end else if (do_pop) begin
            n_rd_slot = rd_next;
        end else begin
            n_rd_slot = r_rd_slot;
        end
        head_slot = slot_inc(n_rd_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_rd_slot <= '0;
        end else begin
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_stamps[wr_next] <= i_stamp;
            r_chans[wr_next]  <= i_chan;
        end
        // The oldest waiting entry is fetched ahead of time; a push into an
        // empty ring lands there directly.
        if (do_push && (wr_next == head_slot)) begin
            r_head_stamp <= i_stamp;
            r_head_chan  <= i_chan;
        end else begin
            r_head_stamp <= r_stamps[head_slot];
            r_head_chan  <= r_chans[head_slot];
        end
    end

    assign o_status.popped = do_pop;
    assign o_status.stamp  = do_pop ? r_head_stamp : '0;
    assign o_status.fill   = imu_idf_pkg::FILL_W'(slot_diff(n_wr_slot, n_rd_slot));
    assign o_chan          = r_head_chan;

endmodule

### rtl/imu_iir_filter_decimating_fifo.sv
`timescale 1ns / 1ps

// IMU sample filter with a decimating ring store. Each input transfer is a
// command: a sample (time plus six raw channels and temperature), a read of
// the oldest stored entry, or a flush of the store. Every command yields
// exactly one result transfer carrying the popped entry or the current
// filtered channels, the latest temperature, the last poll time and the
// number of waiting entries. The block takes one transfer per clock while
// the result side is not stalled; a command passes through the input
// register, then the result register, before its result is offered. The
// six first-order low-pass lanes, each with one 17x16 multiplier feeding a
// saturating add, form the path between the two registers. A stalled result
// side holds the input side back within the same cycle. The ring holds
// RING_ENTRIES-1 entries at most. Configuration writes are meant for an
// idle block.
module imu_iir_filter_decimating_fifo (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Commands.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // now_ms[31:0], raw_ax, raw_ay, raw_az, raw_gx, raw_gy, raw_gz, raw_temp
    input  logic [imu_idf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd[1:0], read_ok[2]
    input  logic [imu_idf_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // Results.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // entry_stamp[31:0], out_ax, out_ay, out_az, out_gx, out_gy, out_gz,
    // out_temp, poll_mark[159:144], fill_count[167:160]
    output logic [imu_idf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // entry_valid[0]
    output logic [imu_idf_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    // Configuration writes.
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [imu_idf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [imu_idf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int NCH = imu_idf_pkg::NUM_CH;
    localparam int SMW = imu_idf_pkg::SAMPLE_W;

    logic [imu_idf_pkg::PERIOD_W-1:0] r_period;
    logic [imu_idf_pkg::DECIM_W-1:0]  r_decim;
    logic [imu_idf_pkg::WEIGHT_W-1:0] r_weight;

    logic                                 r_in_valid;
    logic [imu_idf_pkg::IN_TDATA_W-1:0]   r_in_tdata;
    logic [imu_idf_pkg::IN_TUSER_W-1:0]   r_in_tuser;

    logic                                 r_out_valid;
    logic [imu_idf_pkg::OUT_TDATA_W-1:0]  r_out_tdata;
    logic [imu_idf_pkg::OUT_TUSER_W-1:0]  r_out_tuser;

    logic [15:0]                    r_last_poll;
    logic [15:0]                    n_last_poll;
    logic [imu_idf_pkg::DECIM_W-1:0] r_poll_count;
    logic [imu_idf_pkg::DECIM_W-1:0] n_poll_count;
    logic [imu_idf_pkg::DECIM_W-1:0] count_inc;
    logic [SMW-1:0]                 r_temp;
    logic [SMW-1:0]                 n_temp;

    logic                               advance;
    imu_idf_pkg::t_cmd                  cmd;
    logic                               read_ok;
    logic [imu_idf_pkg::STAMP_W-1:0]    now_ms;
    logic [15:0]                        since_poll;
    logic                               poll_hit;
    logic                               filt_update;
    logic                               store;
    imu_idf_pkg::t_chan_vec             raw_chan;
    imu_idf_pkg::t_chan_vec             filt_next;
    imu_idf_pkg::t_chan_vec             ring_chan;
    imu_idf_pkg::t_chan_vec             out_chan;
    imu_idf_pkg::t_ring_ctrl            ring_ctrl;
    imu_idf_pkg::t_ring_status          ring_status;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= imu_idf_pkg::PERIOD_RESET;
            r_decim  <= imu_idf_pkg::DECIM_RESET;
            r_weight <= imu_idf_pkg::WEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                imu_idf_pkg::REG_PERIOD: r_period <= i_cfg_data;
                imu_idf_pkg::REG_DECIM:  r_decim  <= i_cfg_data[imu_idf_pkg::DECIM_W-1:0];
                imu_idf_pkg::REG_WEIGHT: r_weight <= i_cfg_data[imu_idf_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register; a new command enters while it is empty or whenever the current one moves on.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_tdata <= s_axis_tdata;
            r_in_tuser <= s_axis_tuser;
        end
    end

    // Poll timing and decimation.
    always_comb begin
        cmd        = imu_idf_pkg::t_cmd'(r_in_tuser[1:0]);
        read_ok    = r_in_tuser[2];
        now_ms     = r_in_tdata[31:0];
        for (int i = 0; i < NCH; i++) begin
            raw_chan[i] = r_in_tdata[32 + SMW*i +: SMW];
        end
        since_poll  = now_ms[15:0] - r_last_poll;
        poll_hit    = advance && (cmd == imu_idf_pkg::CMD_SAMPLE)
                    && (since_poll >= r_period);
        filt_update = poll_hit && read_ok;
        count_inc   = r_poll_count + 1'b1;
        store       = poll_hit && (count_inc >= r_decim);

        n_last_poll  = poll_hit ? (r_last_poll + r_period) : r_last_poll;
        if (store) begin
            n_poll_count = '0;
        end else if (poll_hit) begin
            n_poll_count = count_inc;
        end else begin
            n_poll_count = r_poll_count;
        end
        n_temp = filt_update ? r_in_tdata[143:128] : r_temp;

        ring_ctrl.push  = store;
        ring_ctrl.pop   = advance && (cmd == imu_idf_pkg::CMD_READ);
        ring_ctrl.flush = advance && (cmd == imu_idf_pkg::CMD_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_poll  <= '0;
            r_poll_count <= '0;
            r_temp       <= '0;
        end else begin
            r_last_poll  <= n_last_poll;
            r_poll_count <= n_poll_count;
            r_temp       <= n_temp;
        end
    end

    for (genvar g = 0; g < NCH; g++) begin : g_lane
        imu_idf_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_update (filt_update),
            .i_sample (raw_chan[g]),
            .i_weight (r_weight),
            .o_next   (filt_next[g])
        );
    end

    imu_idf_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ring_ctrl),
        .i_stamp  (now_ms),
        .i_chan   (filt_next),
        .o_status (ring_status),
        .o_chan   (ring_chan)
    );

    assign out_chan = ring_status.popped ? ring_chan : filt_next;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tdata <= {ring_status.fill, n_last_poll, n_temp, out_chan,
                            ring_status.stamp};
            r_out_tuser <= ring_status.popped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

### rtl/imu_idf_checker.sv
`timescale 1ns / 1ps

module imu_idf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [imu_idf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [imu_idf_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // No result leaves the block in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Without a popped entry the stamp reads as zero.
    a_stamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0)
        else $error("stamp set without a popped entry");

    // The ring never reports more than it can hold.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[167:160] < imu_idf_pkg::FILL_W'(imu_idf_pkg::RING_ENTRIES))
        else $error("fill count beyond ring size");

endmodule

bind imu_iir_filter_decimating_fifo imu_idf_checker u_imu_idf_checker (.*);

### dv/tb_imu_iir_filter_decimating_fifo.sv
`timescale 1ns / 1ps

module tb_imu_iir_filter_decimating_fifo;
    import imu_idf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint Q30_MAX = 64'sd1073741823;
    localparam longint Q30_MIN = -64'sd1073741824;
    localparam int RING_LIMIT = RING_ENTRIES - 1;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 115;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [STAMP_W-1:0]  now;
        logic                ok;
        t_chan_vec           raw;
        logic [SAMPLE_W-1:0] raw_temp;
    } t_imu_cmd;

    typedef struct packed {
        logic                popped;
        logic [STAMP_W-1:0]  stamp;
        t_chan_vec           chan;
        logic [SAMPLE_W-1:0] temp;
        logic [15:0]         mark;
        logic [FILL_W-1:0]   fill;
    } t_imu_result;

    // Mirror of the filter state, the ring contents and the registers. Each
    // accepted command advances it and queues the result it must produce.
    class imu_state_mirror;
        logic [PERIOD_W-1:0] period;
        logic [DECIM_W-1:0]  decim;
        logic [WEIGHT_W-1:0] weight;
        logic [15:0]         mark;
        logic [7:0]          polls;
        logic [SLOT_W-1:0]   wr_slot;
        logic [SLOT_W-1:0]   rd_slot;
        t_chan_vec           filt;
        logic [SAMPLE_W-1:0] temp;
        logic [STAMP_W-1:0]  ring_stamp [RING_ENTRIES];
        t_chan_vec           ring_chan [RING_ENTRIES];
        t_imu_result         pending_results[$];
        int                  errors;

        function new();
            period  = PERIOD_RESET;
            decim   = DECIM_RESET;
            weight  = WEIGHT_RESET;
            mark    = '0;
            polls   = '0;
            wr_slot = '0;
            rd_slot = '0;
            filt    = '0;
            temp    = '0;
            errors  = 0;
        endfunction

        function logic [SLOT_W-1:0] fill_level();
            return wr_slot - rd_slot;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PERIOD: period = data[PERIOD_W-1:0];
                REG_DECIM:  decim = data[DECIM_W-1:0];
                REG_WEIGHT: weight = data[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [15:0] lowpass(logic signed [15:0] prev,
                                             logic signed [15:0] fresh,
                                             logic [WEIGHT_W-1:0] w);
            longint acc;
            acc = 64'sd16384 + longint'(prev) * longint'(w)
                + longint'(fresh) * (64'sd32768 - longint'(w));
            if (acc > Q30_MAX)
                acc = Q30_MAX;
            else if (acc < Q30_MIN)
                acc = Q30_MIN;
            return 16'(acc >>> 15);
        endfunction

        function void note_command(t_imu_cmd c);
            t_imu_result r;
            r = '0;
            case (c.cmd)
                CMD_SAMPLE: begin
                    if (16'(c.now[15:0] - mark) >= period) begin
                        mark = mark + period;
                        if (c.ok) begin
                            for (int i = 0; i < NUM_CH; i++)
                                filt[i] = lowpass(filt[i], c.raw[i], weight);
                            temp = c.raw_temp;
                        end
                        polls = polls + 8'd1;
                        // A full ring skips the store but the count restarts anyway.
                        if (polls >= decim) begin
                            polls = '0;
                            if (fill_level() < RING_LIMIT) begin
                                wr_slot = wr_slot + 1'b1;
                                ring_stamp[wr_slot] = c.now;
                                ring_chan[wr_slot] = filt;
                            end
                        end
                    end
                end
                CMD_READ: begin
                    if (fill_level() != 0) begin
                        rd_slot = rd_slot + 1'b1;
                        r.popped = 1'b1;
                        r.stamp = ring_stamp[rd_slot];
                    end
                end
                CMD_FLUSH: rd_slot = wr_slot;
                default: ;
            endcase
            r.chan = r.popped ? ring_chan[rd_slot] : filt;
            r.temp = temp;
            r.mark = mark;
            r.fill = FILL_W'(fill_level());
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch in %s: got %h, expected %h (%0t)", what, got, want, $time);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
            t_imu_result e;
            if (pending_results.size() == 0) begin
                report("unexpected result transfer", data[31:0], 32'd0);
                return;
            end
            e = pending_results.pop_front();
            if (user[0] !== e.popped)
                report("entry_valid", 32'(user[0]), 32'(e.popped));
            if (data[31:0] !== e.stamp)
                report("entry_stamp", data[31:0], e.stamp);
            for (int i = 0; i < NUM_CH; i++)
                if (data[32 + 16 * i +: 16] !== e.chan[i])
                    report($sformatf("channel %0d", i), 32'(data[32 + 16 * i +: 16]),
                           32'(e.chan[i]));
            if (data[143:128] !== e.temp)
                report("out_temp", 32'(data[143:128]), 32'(e.temp));
            if (data[159:144] !== e.mark)
                report("poll_mark", 32'(data[159:144]), 32'(e.mark));
            if (data[167:160] !== e.fill)
                report("fill_count", 32'(data[167:160]), 32'(e.fill));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    imu_state_mirror mirror = new();

    imu_iir_filter_decimating_fifo uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                mirror.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    function automatic logic [15:0] random_value();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_imu_cmd sample_cmd(logic [31:0] now, logic ok, logic [15:0] value);
        t_imu_cmd c;
        c.cmd = CMD_SAMPLE;
        c.now = now;
        c.ok = ok;
        for (int i = 0; i < NUM_CH; i++)
            c.raw[i] = value;
        c.raw_temp = value;
        return c;
    endfunction

    // Most sample times land just on or next to the next poll boundary so
    // that polls get accepted; a few are arbitrary.
    function automatic logic [15:0] sample_time();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return mirror.mark + mirror.period - 16'd1;
            default: return mirror.mark + mirror.period + 16'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic t_imu_cmd random_cmd(int read_pct);
        t_imu_cmd c;
        int pick;
        pick = $urandom_range(0, 99);
        c.now = $urandom;
        c.ok = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < NUM_CH; i++)
            c.raw[i] = random_value();
        c.raw_temp = random_value();
        if (pick < read_pct) begin
            c.cmd = CMD_READ;
        end else if (pick < read_pct + 4) begin
            c.cmd = CMD_FLUSH;
        end else if (pick < read_pct + 6) begin
            c.cmd = CMD_UNUSED;
        end else begin
            c.cmd = CMD_SAMPLE;
            c.now[15:0] = sample_time();
        end
        return c;
    endfunction

    function automatic t_imu_cmd op_cmd(logic [1:0] cmd);
        t_imu_cmd c;
        c = random_cmd(0);
        c.cmd = cmd;
        return c;
    endfunction

    // Called at a falling edge; leaves tvalid high so back-to-back transfers
    // need no second assignment in the same step.
    task automatic send_cmd(t_imu_cmd c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c.raw_temp, c.raw, c.now};
        s_axis_tuser <= {c.ok, c.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.note_command(c);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (mirror.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        mirror.write_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [15:0] period, logic [15:0] decim, logic [15:0] weight);
        drain();
        write_reg(REG_PERIOD, period);
        write_reg(REG_DECIM, decim);
        write_reg(REG_WEIGHT, weight);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: period 10, decimation 5.
        send_cmd(op_cmd(CMD_READ));
        send_cmd(sample_cmd(32'd5, 1'b1, 16'h7fff));
        send_cmd(sample_cmd(32'd10, 1'b1, 16'h7fff));
        send_cmd(sample_cmd(32'd20, 1'b1, 16'h7fff));
        send_cmd(sample_cmd(32'd30, 1'b0, 16'h0000));
        send_cmd(sample_cmd(32'd40, 1'b1, 16'h8000));
        send_cmd(sample_cmd(32'hffff_ffff, 1'b1, 16'h8000));
        send_cmd(op_cmd(CMD_READ));
        send_cmd(op_cmd(CMD_UNUSED));
        send_cmd(sample_cmd(32'h0000_0000, 1'b1, 16'h0000));
        send_cmd(op_cmd(CMD_FLUSH));

        // Every poll stores, so the ring runs full and later stores are dropped.
        configure(16'd1, 16'd1, 16'd0);
        repeat (RING_ENTRIES + 1)
            send_cmd(sample_cmd({16'ha5a5, 16'(mirror.mark + 16'd1)}, 1'b1, random_value()));
        send_cmd(op_cmd(CMD_READ));
        send_cmd(op_cmd(CMD_FLUSH));

        configure(16'd0, 16'd0, 16'd32767);
        send_cmd(sample_cmd(32'h5a5a_0000, 1'b1, 16'h7fff));
        send_cmd(sample_cmd(32'h5a5a_0000, 1'b0, 16'h8000));
        send_cmd(op_cmd(CMD_READ));

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: configure(16'd1, 16'd1, 16'd0);
                1: configure(16'hffff, 16'd255, 16'd32767);
                2: configure(16'd0, 16'd0, 16'd16384);
                3: configure(16'd3, 16'd2, 16'($urandom_range(0, 32767)));
                default: configure(16'($urandom_range(1, 20)), 16'($urandom_range(1, 6)),
                                   16'($urandom_range(0, 32767)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // Long result stall while commands keep coming, to back up the pipe.
            if (p == 2)
                hold_left = 300;
            repeat (ITEMS_PER_PHASE)
                send_cmd(random_cmd((p % 2) ? 12 : 30));
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mirror.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
